// ===== hw/rtl/tmbx_pkg.sv =====
// Shared types and constants for the timer and mailbox register block.
package tmbx_pkg;

  localparam int unsigned KIND_W  = 3;
  localparam int unsigned ADDR_W  = 4;
  localparam int unsigned DATA_W  = 8;
  localparam int unsigned TICK_W  = 4;
  localparam int unsigned COUNT_W = 4;
  localparam int unsigned NUM_TIMERS = 3;
  localparam int unsigned NUM_PORTS  = 4;
  localparam int unsigned NUM_SCRATCH = 2;

  typedef enum logic [KIND_W-1:0] {
    KIND_TICK       = 3'd0,
    KIND_CORE_READ  = 3'd1,
    KIND_CORE_WRITE = 3'd2,
    KIND_HOST_READ  = 3'd3,
    KIND_HOST_WRITE = 3'd4
  } kind_t;

  // Register offsets from 0xF0
  localparam logic [ADDR_W-1:0] REG_CONTROL   = 4'h1;
  localparam logic [ADDR_W-1:0] REG_DSP_LATCH = 4'h2;
  localparam logic [ADDR_W-1:0] REG_PORT0     = 4'h4;
  localparam logic [ADDR_W-1:0] REG_PORT3     = 4'h7;
  localparam logic [ADDR_W-1:0] REG_SCRATCH0  = 4'h8;
  localparam logic [ADDR_W-1:0] REG_SCRATCH1  = 4'h9;
  localparam logic [ADDR_W-1:0] REG_TARGET0   = 4'hA;
  localparam logic [ADDR_W-1:0] REG_TARGET2   = 4'hC;
  localparam logic [ADDR_W-1:0] REG_COUNT0    = 4'hD;
  localparam logic [ADDR_W-1:0] REG_COUNT2    = 4'hF;

  // Control register bits
  localparam int unsigned CTRL_BOOT_ROM = 7;
  localparam int unsigned CTRL_CLR_HI   = 5;
  localparam int unsigned CTRL_CLR_LO   = 4;

  typedef struct packed {
    logic              tick;
    logic [TICK_W-1:0] tick_count;
    logic              ctrl_write;
    logic              enable;
    logic              target_write;
    logic [DATA_W-1:0] target;
    logic              count_clear;
  } tmr_ctl_t;

endpackage

// ===== hw/rtl/tmbx_timer.sv =====
// One prescaled interval timer channel: prescaler, stage counter, output count.
module tmbx_timer #(
  parameter int unsigned PERIOD = 128
) (
  input  logic                       clk,
  input  logic                       rst,
  input  tmbx_pkg::tmr_ctl_t         ctl,
  output logic [tmbx_pkg::COUNT_W-1:0] count
);
  import tmbx_pkg::*;

  logic              enable;
  logic [DATA_W-1:0] target;
  logic [DATA_W-1:0] prescale;
  logic [DATA_W-1:0] stage;
  logic [COUNT_W-1:0] out_count;

  logic [DATA_W:0]   psum;
  logic              wrap;
  logic [DATA_W-1:0] prescale_next;
  logic [DATA_W-1:0] stage_inc;
  logic              match;

  always_comb begin
    psum          = {1'b0, prescale} + {{(DATA_W + 1 - TICK_W){1'b0}}, ctl.tick_count};
    wrap          = psum >= (DATA_W + 1)'(PERIOD);
    prescale_next = wrap ? DATA_W'(psum - (DATA_W + 1)'(PERIOD)) : psum[DATA_W-1:0];
    stage_inc     = stage + DATA_W'(1);
    match         = stage_inc == target;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      enable    <= 1'b0;
      target    <= '0;
      prescale  <= '0;
      stage     <= '0;
      out_count <= '0;
    end else if (ctl.tick) begin
      prescale <= prescale_next;
      if (wrap && enable) begin
        if (match) begin
          stage     <= '0;
          out_count <= out_count + COUNT_W'(1);
        end else begin
          stage <= stage_inc;
        end
      end
    end else if (ctl.ctrl_write) begin
      if (!enable && ctl.enable) begin
        stage     <= '0;
        out_count <= '0;
      end
      enable <= ctl.enable;
    end else if (ctl.target_write) begin
      target <= ctl.target;
    end else if (ctl.count_clear) begin
      out_count <= '0;
    end
  end

  assign count = out_count;

endmodule

// ===== hw/rtl/timer_and_mailbox_registers_core.sv =====
// Top level: request register, register decode, mailboxes and result register.
//
// Sound coprocessor I/O registers: three interval timers, control, DSP address
// latch, scratch bytes and four mailbox bytes each way. One request per clock
// is accepted when not stalled, and one result comes back per request, after
// the request register and then the result register. Throughput is one
// request per cycle, set by the single decode and update stage between the
// two registers; m_tready low stalls the result register and, through it,
// the request register. tuser carries the request kind.
module timer_and_mailbox_registers_core #(
  parameter int unsigned SLOW_PRESCALE = 128,
  parameter int unsigned FAST_PRESCALE = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [15:0] s_tdata,   // address[3:0], write_data[11:4], tick_count[15:12]
  input  logic [2:0]  s_tuser,   // kind[2:0]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [15:0] m_tdata    // read_data[7:0], boot_rom_enabled[8], zero[15:9]
);
  import tmbx_pkg::*;

  // Request register
  logic               req_valid;
  logic [KIND_W-1:0]  req_kind;
  logic [ADDR_W-1:0]  req_addr;
  logic [DATA_W-1:0]  req_data;
  logic [TICK_W-1:0]  req_ticks;

  // Result register
  logic               res_valid;
  logic [DATA_W-1:0]  res_data;
  logic               res_boot;

  // Block state
  logic [DATA_W-1:0]  dsp_latch;
  logic [DATA_W-1:0]  scratch   [NUM_SCRATCH];
  logic [DATA_W-1:0]  host_to_core [NUM_PORTS];
  logic [DATA_W-1:0]  core_to_host [NUM_PORTS];
  logic               boot_rom;

  logic               advance;
  logic [DATA_W-1:0]  read_next;
  logic               boot_next;
  logic [1:0]         port_sel;
  logic [1:0]         tmr_sel;
  logic [1:0]         cnt_sel;
  tmr_ctl_t           tmr_ctl   [NUM_TIMERS];
  logic [COUNT_W-1:0] tmr_count [NUM_TIMERS];

  assign advance  = req_valid && (!res_valid || m_tready);
  assign s_tready = !req_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      req_valid <= 1'b0;
    end else if (s_tready) begin
      req_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tready && s_tvalid) begin
      req_kind  <= s_tuser;
      req_addr  <= s_tdata[3:0];
      req_data  <= s_tdata[11:4];
      req_ticks <= s_tdata[15:12];
    end
  end

  assign port_sel = req_addr[1:0];
  assign tmr_sel  = 2'(req_addr - REG_TARGET0);
  assign cnt_sel  = 2'(req_addr - REG_COUNT0);

  always_comb begin
    read_next = '0;
    boot_next = boot_rom;
    for (int t = 0; t < NUM_TIMERS; t++) begin
      tmr_ctl[t] = '0;
      tmr_ctl[t].tick_count = req_ticks;
      tmr_ctl[t].enable     = req_data[t];
      tmr_ctl[t].target     = req_data;
    end
    case (kind_t'(req_kind))
      KIND_TICK: begin
        for (int t = 0; t < NUM_TIMERS; t++) begin
          tmr_ctl[t].tick = advance;
        end
      end
      KIND_CORE_READ: begin
        case (req_addr) inside
          REG_DSP_LATCH:          read_next = dsp_latch;
          [REG_PORT0:REG_PORT3]:  read_next = host_to_core[port_sel];
          REG_SCRATCH0:           read_next = scratch[0];
          REG_SCRATCH1:           read_next = scratch[1];
          [REG_COUNT0:REG_COUNT2]: begin
            read_next = {{(DATA_W - COUNT_W){1'b0}}, tmr_count[cnt_sel]};
            tmr_ctl[cnt_sel].count_clear = advance;
          end
          default:                read_next = '0;
        endcase
      end
      KIND_CORE_WRITE: begin
        case (req_addr) inside
          REG_CONTROL: begin
            boot_next = req_data[CTRL_BOOT_ROM];
            for (int t = 0; t < NUM_TIMERS; t++) begin
              tmr_ctl[t].ctrl_write = advance;
            end
          end
          [REG_TARGET0:REG_TARGET2]: tmr_ctl[tmr_sel].target_write = advance;
          default: ;
        endcase
      end
      KIND_HOST_READ: read_next = core_to_host[port_sel];
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      dsp_latch <= '0;
      boot_rom  <= 1'b1;
      for (int i = 0; i < NUM_SCRATCH; i++) begin
        scratch[i] <= '0;
      end
      for (int i = 0; i < NUM_PORTS; i++) begin
        host_to_core[i] <= '0;
        core_to_host[i] <= '0;
      end
    end else if (advance) begin
      boot_rom <= boot_next;
      case (kind_t'(req_kind))
        KIND_CORE_WRITE: begin
          case (req_addr) inside
            REG_CONTROL: begin
              if (req_data[CTRL_CLR_HI]) begin
                host_to_core[2] <= '0;
                host_to_core[3] <= '0;
              end
              if (req_data[CTRL_CLR_LO]) begin
                host_to_core[0] <= '0;
                host_to_core[1] <= '0;
              end
            end
            REG_DSP_LATCH:         dsp_latch <= req_data;
            [REG_PORT0:REG_PORT3]: core_to_host[port_sel] <= req_data;
            REG_SCRATCH0:          scratch[0] <= req_data;
            REG_SCRATCH1:          scratch[1] <= req_data;
            default: ;
          endcase
        end
        KIND_HOST_WRITE: host_to_core[port_sel] <= req_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (advance) begin
      res_valid <= 1'b1;
    end else if (m_tready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      res_data <= read_next;
      res_boot <= boot_next;
    end
  end

  tmbx_timer #(.PERIOD(SLOW_PRESCALE)) u_timer0 (
    .clk   (clk),
    .rst   (rst),
    .ctl   (tmr_ctl[0]),
    .count (tmr_count[0])
  );

  tmbx_timer #(.PERIOD(SLOW_PRESCALE)) u_timer1 (
    .clk   (clk),
    .rst   (rst),
    .ctl   (tmr_ctl[1]),
    .count (tmr_count[1])
  );

  tmbx_timer #(.PERIOD(FAST_PRESCALE)) u_timer2 (
    .clk   (clk),
    .rst   (rst),
    .ctl   (tmr_ctl[2]),
    .count (tmr_count[2])
  );

  assign m_tvalid = res_valid;
  assign m_tdata  = {7'b0, res_boot, res_data};

endmodule

// ===== dv/tmbx_checker.sv =====
`timescale 1ns / 100ps
// Reply checker for the timer and mailbox register block: tracks state and checks replies.
module tmbx_checker #(
  parameter int unsigned SLOW_PRESCALE = 128,
  parameter int unsigned FAST_PRESCALE = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  input  logic        s_tready,
  input  logic [15:0] s_tdata,
  input  logic [2:0]  s_tuser,
  input  logic        m_tvalid,
  input  logic        m_tready,
  input  logic [15:0] m_tdata,
  output int          fail_count,
  output int          outstanding,
  output int          replies_checked,
  output int          count_hits
);
  import tmbx_pkg::*;

  typedef struct packed {
    logic [DATA_W-1:0] read_data;
    logic              boot_rom;
  } reply_t;

  reply_t reply_q[$];

  logic               timer_on  [NUM_TIMERS];
  logic [DATA_W-1:0]  target    [NUM_TIMERS];
  logic [DATA_W-1:0]  prescale  [NUM_TIMERS];
  logic [DATA_W-1:0]  stage     [NUM_TIMERS];
  logic [COUNT_W-1:0] out_cnt   [NUM_TIMERS];
  logic [DATA_W-1:0]  dsp_latch;
  logic [DATA_W-1:0]  scratch   [NUM_SCRATCH];
  logic [DATA_W-1:0]  from_host [NUM_PORTS];
  logic [DATA_W-1:0]  to_host   [NUM_PORTS];
  logic               boot_rom;

  function automatic void clear_state();
    for (int t = 0; t < NUM_TIMERS; t++) begin
      timer_on[t] = 1'b0;
      target[t]   = '0;
      prescale[t] = '0;
      stage[t]    = '0;
      out_cnt[t]  = '0;
    end
    for (int i = 0; i < NUM_SCRATCH; i++) scratch[i] = '0;
    for (int i = 0; i < NUM_PORTS; i++) begin
      from_host[i] = '0;
      to_host[i]   = '0;
    end
    dsp_latch = '0;
    boot_rom  = 1'b1;
  endfunction

  // Prescaler wraps at most once per tick; remainder carries.
  function automatic void advance_timer(int t, logic [TICK_W-1:0] cycles, int unsigned period);
    int unsigned p;
    p = prescale[t] + cycles;
    if (p >= period) begin
      p -= period;
      if (timer_on[t]) begin
        stage[t] = stage[t] + 1'b1;
        if (stage[t] == target[t]) begin
          stage[t]   = '0;
          out_cnt[t] = out_cnt[t] + 1'b1;
        end
      end
    end
    prescale[t] = DATA_W'(p);
  endfunction

  function automatic logic [DATA_W-1:0] read_core(logic [ADDR_W-1:0] addr);
    logic [DATA_W-1:0] r;
    r = '0;
    if (addr == REG_DSP_LATCH) begin
      r = dsp_latch;
    end else if (addr >= REG_PORT0 && addr <= REG_PORT3) begin
      r = from_host[addr[1:0]];
    end else if (addr == REG_SCRATCH0) begin
      r = scratch[0];
    end else if (addr == REG_SCRATCH1) begin
      r = scratch[1];
    end else if (addr >= REG_COUNT0) begin
      r = DATA_W'(out_cnt[addr - REG_COUNT0]);
      out_cnt[addr - REG_COUNT0] = '0;
      if (r != '0) count_hits++;
    end
    return r;
  endfunction

  function automatic void write_core(logic [ADDR_W-1:0] addr, logic [DATA_W-1:0] data);
    if (addr == REG_CONTROL) begin
      boot_rom = data[CTRL_BOOT_ROM];
      if (data[CTRL_CLR_HI]) begin
        from_host[2] = '0;
        from_host[3] = '0;
      end
      if (data[CTRL_CLR_LO]) begin
        from_host[0] = '0;
        from_host[1] = '0;
      end
      for (int t = 0; t < NUM_TIMERS; t++) begin
        if (!timer_on[t] && data[t]) begin
          stage[t]   = '0;
          out_cnt[t] = '0;
        end
        timer_on[t] = data[t];
      end
    end else if (addr == REG_DSP_LATCH) begin
      dsp_latch = data;
    end else if (addr >= REG_PORT0 && addr <= REG_PORT3) begin
      to_host[addr[1:0]] = data;
    end else if (addr == REG_SCRATCH0) begin
      scratch[0] = data;
    end else if (addr == REG_SCRATCH1) begin
      scratch[1] = data;
    end else if (addr >= REG_TARGET0 && addr <= REG_TARGET2) begin
      target[addr - REG_TARGET0] = data;
    end
  endfunction

  function automatic reply_t predict_reply(logic [KIND_W-1:0] kind, logic [ADDR_W-1:0] addr,
                                           logic [DATA_W-1:0] data, logic [TICK_W-1:0] cycles);
    reply_t r;
    r.read_data = '0;
    case (kind_t'(kind))
      KIND_TICK: begin
        for (int t = 0; t < NUM_TIMERS; t++)
          advance_timer(t, cycles, (t == NUM_TIMERS - 1) ? FAST_PRESCALE : SLOW_PRESCALE);
      end
      KIND_CORE_READ:  r.read_data = read_core(addr);
      KIND_CORE_WRITE: write_core(addr, data);
      KIND_HOST_READ:  r.read_data = to_host[addr[1:0]];
      KIND_HOST_WRITE: from_host[addr[1:0]] = data;
      default: ;
    endcase
    r.boot_rom = boot_rom;
    return r;
  endfunction

  function automatic void log_failure(string msg);
    fail_count++;
    if (fail_count <= 10) $display("[%0t] MISMATCH: %s", $realtime, msg);
  endfunction

  always @(posedge clk) begin
    reply_t want;
    if (rst) begin
      clear_state();
      reply_q.delete();
      fail_count      = 0;
      replies_checked = 0;
      count_hits      = 0;
    end else begin
      // replies first so a stray reply cannot match a request taken this edge
      if (m_tvalid && m_tready) begin
        if (reply_q.size() == 0) begin
          log_failure($sformatf("reply %04h with no request pending", m_tdata));
        end else begin
          want = reply_q.pop_front();
          if (m_tdata[7:0] !== want.read_data || m_tdata[8] !== want.boot_rom ||
              m_tdata[15:9] !== '0)
            log_failure($sformatf(
              {"reply %0d: expected read_data %02h boot_rom %0b, ",
               "got read_data %02h boot_rom %0b pad %02h"},
              replies_checked, want.read_data, want.boot_rom, m_tdata[7:0], m_tdata[8],
              m_tdata[15:9]));
          replies_checked++;
        end
      end
      if (s_tvalid && s_tready)
        reply_q.push_back(predict_reply(s_tuser, s_tdata[3:0], s_tdata[11:4], s_tdata[15:12]));
    end
    outstanding <= reply_q.size();
  end

endmodule

// ===== dv/tb.sv =====
`timescale 1ns / 100ps
// Testbench top for the timer and mailbox register block: stimulus, flow control and verdict.
module tb;
  import tmbx_pkg::*;

  localparam int unsigned RUN_LIMIT        = 200000;
  localparam int unsigned RANDOM_PER_PHASE = 475;
  localparam int unsigned HOLD_CYCLES      = 48;
  localparam logic [ADDR_W-1:0] REG_SPARE0    = 4'h0;
  localparam logic [ADDR_W-1:0] REG_SPARE3    = 4'h3;
  localparam logic [KIND_W-1:0] KIND_SPARE_LO = 3'd5;
  localparam logic [KIND_W-1:0] KIND_SPARE_HI = 3'd7;

  logic        clk      = 1'b0;
  logic        rst      = 1'b1;
  logic        s_tvalid = 1'b0;
  logic [15:0] s_tdata  = '0;
  logic [2:0]  s_tuser  = '0;
  logic        m_tready = 1'b0;
  logic        s_tready;
  logic        m_tvalid;
  logic [15:0] m_tdata;

  int idle_pct    = 0;
  int stall_pct   = 0;
  int hold_req    = 0;
  int hold_seen   = 0;
  int hold_left   = 0;
  int cycle_count = 0;
  int sent        = 0;
  int fail_count;
  int outstanding;
  int replies_checked;
  int count_hits;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  timer_and_mailbox_registers_core dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  tmbx_checker reply_check (
    .clk             (clk),
    .rst             (rst),
    .s_tvalid        (s_tvalid),
    .s_tready        (s_tready),
    .s_tdata         (s_tdata),
    .s_tuser         (s_tuser),
    .m_tvalid        (m_tvalid),
    .m_tready        (m_tready),
    .m_tdata         (m_tdata),
    .fail_count      (fail_count),
    .outstanding     (outstanding),
    .replies_checked (replies_checked),
    .count_hits      (count_hits)
  );

  // result side: random stalls, plus a long hold-off on request
  always @(posedge clk) begin
    if (hold_left > 0) begin
      m_tready  <= 1'b0;
      hold_left <= hold_left - 1;
    end else if (hold_seen != hold_req) begin
      hold_seen <= hold_req;
      hold_left <= HOLD_CYCLES;
      m_tready  <= 1'b0;
    end else begin
      m_tready <= ($urandom_range(99) >= stall_pct);
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > RUN_LIMIT) begin
      $display("Timeout after %0d cycles, %0d replies outstanding", cycle_count, outstanding);
      $display("Regression FAIL");
      $finish;
    end
  end

  task automatic send_request(logic [KIND_W-1:0] kind, logic [ADDR_W-1:0] addr,
                              logic [DATA_W-1:0] data, logic [TICK_W-1:0] ticks);
    while ($urandom_range(99) < idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= kind;
    s_tdata  <= {ticks, data, addr};
    do @(posedge clk); while (!s_tready);
    sent++;
  endtask

  task automatic drain();
    s_tvalid <= 1'b0;
    do @(posedge clk); while (outstanding != 0);
  endtask

  // Mostly ticks and timer traffic with small targets so counts move often.
  task automatic random_request();
    int                pick;
    logic [KIND_W-1:0] k;
    logic [ADDR_W-1:0] a;
    logic [DATA_W-1:0] d;
    logic [TICK_W-1:0] c;
    a    = ADDR_W'($urandom);
    d    = DATA_W'($urandom);
    c    = TICK_W'($urandom);
    pick = $urandom_range(99);
    if (pick < 45) begin
      k = KIND_TICK;
    end else if (pick < 62) begin
      k = KIND_CORE_READ;
      if ($urandom_range(1)) a = REG_COUNT0 + ADDR_W'($urandom_range(2));
    end else if (pick < 74) begin
      k = KIND_CORE_WRITE;
      case ($urandom_range(4))
        0, 1: begin
          a = REG_TARGET0 + ADDR_W'($urandom_range(2));
          if ($urandom_range(3) != 0) d = DATA_W'($urandom_range(4));
        end
        2: begin
          a = REG_CONTROL;
          if ($urandom_range(3) != 0) d[2:0] = 3'b111;
        end
        default: ;
      endcase
    end else if (pick < 85) begin
      k = KIND_HOST_WRITE;
    end else if (pick < 96) begin
      k = KIND_HOST_READ;
    end else begin
      k = KIND_W'($urandom_range(KIND_SPARE_LO, KIND_SPARE_HI));
    end
    send_request(k, a, d, c);
  endtask

  initial begin
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    send_request(KIND_CORE_READ,  REG_CONTROL,   8'h00, 4'h0);
    send_request(KIND_CORE_WRITE, REG_SPARE0,    8'hFF, 4'hF);
    send_request(KIND_CORE_READ,  REG_SPARE3,    8'h00, 4'h0);
    send_request(KIND_CORE_WRITE, REG_DSP_LATCH, 8'hFF, 4'h0);
    send_request(KIND_CORE_READ,  REG_DSP_LATCH, 8'h00, 4'h0);
    send_request(KIND_HOST_WRITE, REG_PORT3,     8'hA5, 4'h0);
    send_request(KIND_CORE_READ,  REG_PORT3,     8'h00, 4'h0);
    send_request(KIND_CORE_WRITE, REG_PORT0,     8'h5A, 4'h0);
    send_request(KIND_HOST_READ,  REG_PORT0,     8'h00, 4'h0);
    send_request(KIND_CORE_WRITE, REG_SCRATCH1,  8'hFF, 4'h0);
    send_request(KIND_CORE_READ,  REG_SCRATCH1,  8'h00, 4'h0);
    send_request(KIND_CORE_WRITE, REG_TARGET0,   8'h01, 4'h0);
    send_request(KIND_CORE_WRITE, REG_TARGET0 + 4'h1, 8'hFF, 4'h0);
    send_request(KIND_CORE_WRITE, REG_TARGET2,   8'h00, 4'h0);
    // boot ROM on, clear both host port pairs, enable all timers
    send_request(KIND_CORE_WRITE, REG_CONTROL,   8'hB7, 4'h0);
    send_request(KIND_CORE_READ,  REG_PORT3,     8'h00, 4'h0);
    send_request(KIND_TICK,       REG_SPARE0,    8'h00, 4'h0);
    repeat (3) send_request(KIND_TICK, REG_SPARE0, 8'h00, 4'hF);
    send_request(KIND_TICK,       REG_SPARE0,    8'h00, 4'h1);
    send_request(KIND_CORE_READ,  REG_COUNT0,    8'h00, 4'h0);
    send_request(KIND_CORE_READ,  REG_COUNT2,    8'h00, 4'h0);
    send_request(KIND_SPARE_HI,   REG_COUNT2,    8'hFF, 4'hF);
    send_request(KIND_CORE_WRITE, REG_CONTROL,   8'h00, 4'h0);
    send_request(KIND_CORE_READ,  REG_TARGET2,   8'h00, 4'h0);
    drain();

    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin idle_pct = 0;  stall_pct <= 0;  end
        1: begin idle_pct = 55; stall_pct <= 0;  end
        2: begin idle_pct = 0;  stall_pct <= 55; end
        default: begin idle_pct = 23; stall_pct <= 23; end
      endcase
      for (int i = 0; i < RANDOM_PER_PHASE; i++) begin
        if (phase == 0 && i == 100) hold_req <= hold_req + 1;
        random_request();
      end
      drain();
    end

    repeat (20) @(posedge clk);
    $display("Covered %0d requests in four flow-control phases with a long result hold-off;",
             sent);
    $display("%0d replies checked, %0d timer count reads returned a nonzero count.",
             replies_checked, count_hits);
    if (fail_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("%0d mismatches", fail_count);
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
